FILE: sv/playfair_digraph_cipher_unit_defines.svh
// Assertion helpers for the cipher unit
`ifndef PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_UNIT_DEFINES_SVH

// same-cycle implication
`define PFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfc check failed");

// next-cycle implication
`define PFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfc check failed");

`endif

FILE: sv/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  localparam int SQ_SIDE     = 5;
  localparam int SQ_CELLS    = 25;
  localparam int NUM_LETTERS = 26;
  localparam int LETTER_W    = 5;
  localparam int RC_W        = 3;

  localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
  localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;

  localparam logic [1:0] MODE_KEY     = 2'd0;
  localparam logic [1:0] MODE_FINISH  = 2'd1;
  localparam logic [1:0] MODE_ENCRYPT = 2'd2;
  localparam logic [1:0] MODE_DECRYPT = 2'd3;

  typedef struct packed {
    logic [1:0]          mode;
    logic [LETTER_W-1:0] letter_a;
    logic [LETTER_W-1:0] letter_b;
  } pfc_req_t;

  typedef struct packed {
    logic [LETTER_W-1:0] out_first;
    logic [LETTER_W-1:0] out_second;
  } pfc_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_FILL,
    ST_LOOKUP,
    ST_LOOK_A,
    ST_LOOK_B,
    ST_CELL_1,
    ST_CELL_2
  } pfc_state_t;

endpackage
`default_nettype wire

FILE: sv/pfc_if.sv
`default_nettype none
interface pfc_in_if;
  import pfc_pkg::*;
  logic     valid;
  logic     ready;
  pfc_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfc_out_if;
  import pfc_pkg::*;
  logic     valid;
  logic     ready;
  pfc_res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/playfair_digraph_cipher_unit.sv
// Playfair cipher unit, 5x5 key square.
// in_ch carries one request: mode, letter_a, letter_b. out_ch carries one
// result (out_first, out_second) for each encrypt or decrypt request; key and
// finish requests give none. A request is taken when valid and ready are high.
// in_ch.ready is high only while the sequencer is idle; one request at a time.
// Steps per request, after the accept:
//   key letter : one place step (ST_KEY)
//   finish     : a fill step per letter (ST_FILL), then one lookup step
//                per written cell and a closing step (ST_LOOKUP)
//   pair       : ST_LOOK_A, ST_LOOK_B, ST_CELL_1, ST_CELL_2, then the result
//                shows from the output register. Each table has one read port.
// The result sits in an output register; if out_ch stalls, a following pair
// waits in its last step until the register frees, while key and finish
// requests go on. Synchronous reset empties the square, the used marks, the
// fill count and the row and column lookups, and drops any pending result.
`default_nettype none
`include "playfair_digraph_cipher_unit_defines.svh"

module playfair_digraph_cipher_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  pfc_in_if.sink     in_ch,
  pfc_out_if.source  out_ch
);
  import pfc_pkg::*;

  pfc_state_t state, state_next;

  logic [LETTER_W-1:0] key_square [SQ_CELLS];
  logic [NUM_LETTERS-1:0] letter_used;
  logic [LETTER_W-1:0] fill_position;
  logic [RC_W-1:0] letter_row [NUM_LETTERS];
  logic [RC_W-1:0] letter_col [NUM_LETTERS];

  logic [1:0]          mode_q;
  logic [LETTER_W-1:0] a_q, b_q;
  logic [LETTER_W-1:0] cnt;
  logic [RC_W-1:0]     row_cnt, col_cnt;
  logic [RC_W-1:0]     r1, c1, r2, c2;
  logic [LETTER_W-1:0] first_q;
  logic                out_valid;
  pfc_res_t            out_data;

  logic                accept, out_load;
  logic                is_dec;
  logic [LETTER_W-1:0] used_addr, place_letter, lk_addr, ks_addr, ks_rd, idx1, idx2;
  logic                used_rd, place_en;
  logic [RC_W-1:0]     lk_row, lk_col;

  function automatic logic [RC_W-1:0] wrap_step(input logic [RC_W-1:0] v, input logic dec);
    logic [RC_W-1:0] r;
    if (dec) begin
      r = (v == '0) ? RC_W'(SQ_SIDE - 1) : v - RC_W'(1);
    end else begin
      r = (v == RC_W'(SQ_SIDE - 1)) ? '0 : v + RC_W'(1);
    end
    return r;
  endfunction

  function automatic logic [LETTER_W-1:0] cell_idx(input logic [RC_W-1:0] r,
                                                    input logic [RC_W-1:0] c);
    logic [LETTER_W-1:0] rr;
    rr = {{(LETTER_W-RC_W){1'b0}}, r};
    return (rr << 2) + rr + {{(LETTER_W-RC_W){1'b0}}, c};
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign is_dec = (mode_q == MODE_DECRYPT);

  // shared read ports
  always_comb begin
    used_addr = (state == ST_KEY) ? a_q : cnt;
    used_rd   = (used_addr < LETTER_W'(NUM_LETTERS)) ? letter_used[used_addr] : 1'b1;
    place_letter = used_addr;
    place_en  = ((state == ST_KEY) || (state == ST_FILL)) && !used_rd &&
                (fill_position < LETTER_W'(SQ_CELLS));

    lk_addr = (state == ST_LOOK_A) ? a_q : b_q;
    if (lk_addr < LETTER_W'(NUM_LETTERS)) begin
      lk_row = letter_row[lk_addr];
      lk_col = letter_col[lk_addr];
    end else begin
      lk_row = '0;
      lk_col = '0;
    end

    if (r1 == r2) begin
      idx1 = cell_idx(r1, wrap_step(c1, is_dec));
      idx2 = cell_idx(r2, wrap_step(c2, is_dec));
    end else if (c1 == c2) begin
      idx1 = cell_idx(wrap_step(r1, is_dec), c1);
      idx2 = cell_idx(wrap_step(r2, is_dec), c2);
    end else begin
      idx1 = cell_idx(r1, c2);
      idx2 = cell_idx(r2, c1);
    end

    unique case (state)
      ST_LOOKUP: ks_addr = cnt;
      ST_CELL_1: ks_addr = idx1;
      default:   ks_addr = idx2;
    endcase
    ks_rd = (ks_addr < LETTER_W'(SQ_CELLS)) ? key_square[ks_addr] : '0;
  end

  // sequencer
  always_comb begin
    state_next  = state;
    in_ch.ready = (state == ST_IDLE);
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.data.mode)
            MODE_KEY:    state_next = ST_KEY;
            MODE_FINISH: state_next = ST_FILL;
            default:     state_next = ST_LOOK_A;
          endcase
        end
      end
      ST_KEY: state_next = ST_IDLE;
      ST_FILL: begin
        if (cnt == LETTER_W'(NUM_LETTERS - 1)) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (cnt == fill_position) state_next = ST_IDLE;
      end
      ST_LOOK_A: state_next = ST_LOOK_B;
      ST_LOOK_B: state_next = ST_CELL_1;
      ST_CELL_1: state_next = ST_CELL_2;
      ST_CELL_2: begin
        if (!out_valid || out_ch.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // key square and lookups
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQ_CELLS; k++) key_square[k] <= '0;
      for (int k = 0; k < NUM_LETTERS; k++) begin
        letter_row[k] <= '0;
        letter_col[k] <= '0;
      end
      letter_used   <= '0;
      fill_position <= '0;
    end else begin
      if (place_en) begin
        key_square[fill_position] <= place_letter;
        fill_position             <= fill_position + LETTER_W'(1);
        letter_used[place_letter] <= 1'b1;
        if (place_letter == LETTER_I || place_letter == LETTER_J) begin
          letter_used[LETTER_I] <= 1'b1;
          letter_used[LETTER_J] <= 1'b1;
        end
      end
      if (state == ST_LOOKUP && cnt != fill_position &&
          ks_rd < LETTER_W'(NUM_LETTERS)) begin
        letter_row[ks_rd] <= row_cnt;
        letter_col[ks_rd] <= col_cnt;
        if (ks_rd == LETTER_I || ks_rd == LETTER_J) begin
          letter_row[LETTER_I] <= row_cnt;
          letter_col[LETTER_I] <= col_cnt;
          letter_row[LETTER_J] <= row_cnt;
          letter_col[LETTER_J] <= col_cnt;
        end
      end
    end
  end

  // request capture and counters
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= in_ch.data.mode;
      a_q    <= in_ch.data.letter_a;
      b_q    <= in_ch.data.letter_b;
    end
    unique case (state)
      ST_IDLE: cnt <= '0;
      ST_FILL: begin
        if (state_next == ST_LOOKUP) begin
          cnt     <= '0;
          row_cnt <= '0;
          col_cnt <= '0;
        end else begin
          cnt <= cnt + LETTER_W'(1);
        end
      end
      ST_LOOKUP: begin
        cnt <= cnt + LETTER_W'(1);
        if (col_cnt == RC_W'(SQ_SIDE - 1)) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + RC_W'(1);
        end else begin
          col_cnt <= col_cnt + RC_W'(1);
        end
      end
      ST_LOOK_A: begin
        r1 <= lk_row;
        c1 <= lk_col;
      end
      ST_LOOK_B: begin
        r2 <= lk_row;
        c2 <= lk_col;
      end
      ST_CELL_1: first_q <= ks_rd;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_data.out_first  <= first_q;
      out_data.out_second <= ks_rd;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  `PFC_ASSERT_NEXT(a_busy_after_accept, accept, state != ST_IDLE)
  `PFC_ASSERT_NOW(a_fill_bounded, 1'b1, fill_position <= LETTER_W'(SQ_CELLS))
  `PFC_ASSERT_NOW(a_result_from_pair, $rose(out_valid), $past(state) == ST_CELL_2)

endmodule
`default_nettype wire

FILE: sim/tb_playfair_digraph_cipher_unit.sv
module tb_playfair_digraph_cipher_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;

  logic clk;
  logic rst;

  pfc_in_if  in_if ();
  pfc_out_if out_if ();

  playfair_digraph_cipher_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  pfc_req_t request_q [$];
  pfc_res_t cipher_expected_q [$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int          issued_cnt;
  int          taken_cnt;
  int          mismatch_cnt;
  int          cycle_cnt;
  logic        req_taken;

  // key square as the block should hold it
  logic [LETTER_W-1:0] sq_cell [SQ_CELLS];
  bit                  sq_used [NUM_LETTERS];
  int                  sq_fill;
  logic [RC_W-1:0]     ltr_row [NUM_LETTERS];
  logic [RC_W-1:0]     ltr_col [NUM_LETTERS];

  task automatic square_place(input logic [LETTER_W-1:0] ltr);
    if (sq_fill < SQ_CELLS) begin
      sq_cell[sq_fill] = ltr;
      sq_fill++;
      sq_used[ltr] = 1'b1;
      if (ltr == LETTER_I || ltr == LETTER_J) begin
        sq_used[LETTER_I] = 1'b1;
        sq_used[LETTER_J] = 1'b1;
      end
    end
  endtask

  function automatic logic [LETTER_W-1:0] square_at(input int r, input int c);
    return sq_cell[((r % SQ_SIDE) * SQ_SIDE + (c % SQ_SIDE)) % SQ_CELLS];
  endfunction

  task automatic playfair_apply(input pfc_req_t req);
    int r1, c1, r2, c2, sh;
    logic [LETTER_W-1:0] ltr;
    pfc_res_t res;
    case (req.mode)
      MODE_KEY: begin
        if (req.letter_a < NUM_LETTERS && !sq_used[req.letter_a])
          square_place(req.letter_a);
      end
      MODE_FINISH: begin
        for (int n = 0; n < NUM_LETTERS; n++)
          if (!sq_used[n]) square_place(LETTER_W'(n));
        for (int pos = 0; pos < sq_fill && pos < SQ_CELLS; pos++) begin
          ltr = sq_cell[pos];
          if (ltr < NUM_LETTERS) begin
            ltr_row[ltr] = RC_W'(pos / SQ_SIDE);
            ltr_col[ltr] = RC_W'(pos % SQ_SIDE);
            if (ltr == LETTER_I || ltr == LETTER_J) begin
              ltr_row[LETTER_I] = RC_W'(pos / SQ_SIDE);
              ltr_col[LETTER_I] = RC_W'(pos % SQ_SIDE);
              ltr_row[LETTER_J] = RC_W'(pos / SQ_SIDE);
              ltr_col[LETTER_J] = RC_W'(pos % SQ_SIDE);
            end
          end
        end
      end
      MODE_ENCRYPT, MODE_DECRYPT: begin
        r1 = (req.letter_a < NUM_LETTERS) ? ltr_row[req.letter_a] % SQ_SIDE : 0;
        c1 = (req.letter_a < NUM_LETTERS) ? ltr_col[req.letter_a] % SQ_SIDE : 0;
        r2 = (req.letter_b < NUM_LETTERS) ? ltr_row[req.letter_b] % SQ_SIDE : 0;
        c2 = (req.letter_b < NUM_LETTERS) ? ltr_col[req.letter_b] % SQ_SIDE : 0;
        sh = (req.mode == MODE_ENCRYPT) ? 1 : SQ_SIDE - 1;
        if (r1 == r2) begin
          res.out_first  = square_at(r1, c1 + sh);
          res.out_second = square_at(r2, c2 + sh);
        end else if (c1 == c2) begin
          res.out_first  = square_at(r1 + sh, c1);
          res.out_second = square_at(r2 + sh, c2);
        end else begin
          res.out_first  = square_at(r1, c2);
          res.out_second = square_at(r2, c1);
        end
        cipher_expected_q.push_back(res);
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || req_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          in_if.data  <= request_q.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // result check and prediction
  always @(posedge clk) begin
    pfc_res_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Mismatches found");
      $finish;
    end
    if (rst) begin
      req_taken <= 1'b0;
      sq_fill = 0;
      for (int k = 0; k < SQ_CELLS; k++) sq_cell[k] = '0;
      for (int k = 0; k < NUM_LETTERS; k++) begin
        sq_used[k] = 1'b0;
        ltr_row[k] = '0;
        ltr_col[k] = '0;
      end
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cipher_expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d %0d", $time,
                   out_if.data.out_first, out_if.data.out_second);
          mismatch_cnt++;
        end else begin
          want = cipher_expected_q.pop_front();
          if (out_if.data.out_first !== want.out_first) begin
            $display("%0t: out_first expected %0d, got %0d", $time,
                     want.out_first, out_if.data.out_first);
            mismatch_cnt++;
          end
          if (out_if.data.out_second !== want.out_second) begin
            $display("%0t: out_second expected %0d, got %0d", $time,
                     want.out_second, out_if.data.out_second);
            mismatch_cnt++;
          end
        end
      end
      req_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        playfair_apply(in_if.data);
        taken_cnt++;
      end
    end
  end

  task automatic queue_request(input logic [1:0] m, input logic [LETTER_W-1:0] a,
                               input logic [LETTER_W-1:0] b);
    pfc_req_t req;
    req.mode     = m;
    req.letter_a = a;
    req.letter_b = b;
    request_q.push_back(req);
    issued_cnt++;
  endtask

  function automatic logic [LETTER_W-1:0] pick_letter();
    if ($urandom_range(99) < 10) return LETTER_W'($urandom_range(31, NUM_LETTERS));
    return LETTER_W'($urandom_range(NUM_LETTERS - 1));
  endfunction

  task automatic queue_random(input int pairs);
    int n;
    n = 0;
    while (n < pairs) begin
      if ($urandom_range(99) < 12) begin
        // noise: square is full, so these change nothing
        if ($urandom_range(3) == 0)
          queue_request(MODE_FINISH, LETTER_W'($urandom_range(31)),
                        LETTER_W'($urandom_range(31)));
        else
          queue_request(MODE_KEY, LETTER_W'($urandom_range(31)),
                        LETTER_W'($urandom_range(31)));
      end else begin
        queue_request($urandom_range(1) ? MODE_ENCRYPT : MODE_DECRYPT,
                      pick_letter(), pick_letter());
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (taken_cnt != issued_cnt || cipher_expected_q.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    snd_idle_pct = 35;
    rcv_idle_pct = 71;
    issued_cnt   = 0;
    taken_cnt    = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // pair on an empty square
    queue_request(MODE_ENCRYPT, 5'd0, 5'd25);
    // key: out-of-range, j then i, duplicate letter
    queue_request(MODE_KEY, 5'd30, 5'd31);
    queue_request(MODE_KEY, LETTER_J, 5'd0);
    queue_request(MODE_KEY, LETTER_I, 5'd17);
    queue_request(MODE_KEY, 5'd15, 5'd2);
    queue_request(MODE_KEY, 5'd11, 5'd29);
    queue_request(MODE_KEY, 5'd0, 5'd6);
    queue_request(MODE_KEY, 5'd0, 5'd31);
    queue_request(MODE_KEY, 5'd31, 5'd1);
    queue_request(MODE_KEY, 5'd24, 5'd12);
    queue_request(MODE_KEY, 5'd25, 5'd20);
    // pair before finish, lookups still at reset
    queue_request(MODE_DECRYPT, 5'd3, 5'd17);
    queue_request(MODE_FINISH, 5'd31, 5'd31);
    queue_request(MODE_FINISH, 5'd0, 5'd0);
    queue_request(MODE_KEY, 5'd1, 5'd3);
    // square: j p l a y / z b c d e / f g h k m / n o q r s / t u v w x
    queue_request(MODE_ENCRYPT, 5'd15, 5'd24);
    queue_request(MODE_DECRYPT, 5'd0, 5'd17);
    queue_request(MODE_ENCRYPT, 5'd1, 5'd18);
    queue_request(MODE_ENCRYPT, 5'd24, LETTER_J);
    queue_request(MODE_DECRYPT, 5'd19, LETTER_J);
    queue_request(MODE_ENCRYPT, LETTER_I, LETTER_J);
    queue_request(MODE_ENCRYPT, 5'd4, 5'd4);
    queue_request(MODE_DECRYPT, 5'd31, 5'd26);
    queue_request(MODE_DECRYPT, 5'd0, 5'd31);
    queue_request(MODE_ENCRYPT, 5'd25, 5'd0);
    queue_random(120);
    wait_drained();

    snd_idle_pct = 71;
    rcv_idle_pct = 35;
    queue_random(120);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_random(100);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && cipher_expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: playfair_digraph_cipher_unit.f
+incdir+sv
sv/pfc_pkg.sv
sv/pfc_if.sv
sv/playfair_digraph_cipher_unit.sv
sim/tb_playfair_digraph_cipher_unit.sv
